### hw/rtl/hme_pkg.sv
// Shared constants, codes, types and helpers of the hashed multimap engine.
package hme_pkg;

  localparam int NODES      = 64;
  localparam int SLOTS      = 128;
  localparam int NODE_W     = 6;
  localparam int SLOT_W     = 7;
  localparam int KEY_W      = 64;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 7;
  localparam int USED_W     = 8;
  localparam int HASH_SHIFT = 33;
  localparam int LOAD_NUM   = 7;
  localparam int LOAD_DEN   = 10;
  localparam int LIM_W      = 16;

  localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [NODE_W:0] NODE_END = (NODE_W+1)'(NODES);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_FIRST  = 3'd2;
  localparam logic [2:0] OP_NEXT   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_COUNT  = 3'd5;
  localparam logic [2:0] OP_VISIT  = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_POOL_FULL = 3'd2;
  localparam logic [2:0] ST_LOAD      = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  localparam logic [1:0] SL_EMPTY = 2'd0;
  localparam logic [1:0] SL_USED  = 2'd1;
  localparam logic [1:0] SL_TOMB  = 2'd2;

  typedef struct packed {
    logic [2:0]       status;
    logic [NODE_W-1:0] node;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             alive;
    logic [CNT_W-1:0] count;
    logic             last;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_POP_RD, S_POP, S_ADD_WR, S_HSTART, S_HASH, S_PRB_RD, S_PRB_CHK,
    S_ADD_NEW, S_AF_RD, S_AF_LINK, S_AF_LINK2, S_RM_RD, S_RM_LINK, S_RM_SLOT,
    S_RM_FREE, S_NX_RD, S_NX, S_RD_RD, S_RD, S_WALK_RD, S_WALK, S_EMIT
  } state_t;

  function automatic res_t mk_res(input logic [2:0] status, input logic [NODE_W-1:0] node,
                                  input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value,
                                  input logic alive, input logic [CNT_W-1:0] count,
                                  input logic last);
    res_t r;
    r.status = status;
    r.node   = node;
    r.key    = key;
    r.value  = value;
    r.alive  = alive;
    r.count  = count;
    r.last   = last;
    return r;
  endfunction

endpackage

### hw/rtl/hme_hash.sv
// Slot hash: 64-bit mixer on one shared 32x32 multiplier, three steps per product.
module hme_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hme_pkg::KEY_W-1:0]  key,
  output logic                       done,
  output logic [hme_pkg::SLOT_W-1:0] slot
);
  import hme_pkg::*;

  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_HL = 2'd1;
  localparam logic [1:0] PH_LH = 2'd2;

  logic [KEY_W-1:0] x_r, x_nxt, acc_r, acc_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             round_r, round_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [31:0]      a_op, c_op;
  logic [KEY_W-1:0] c_full, prod, sum;

  always_comb begin
    c_full = round_r ? MIX_C2 : MIX_C1;
    a_op   = (phase_r == PH_HL) ? x_r[63:32] : x_r[31:0];
    c_op   = (phase_r == PH_LH) ? c_full[63:32] : c_full[31:0];
    prod   = 64'(a_op) * 64'(c_op);
    sum    = acc_r + {prod[31:0], 32'd0};

    x_nxt     = x_r;
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    round_nxt = round_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      x_nxt     = key ^ (key >> HASH_SHIFT);
      phase_nxt = PH_LL;
      round_nxt = 1'b0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      case (phase_r)
        PH_LL: begin
          acc_nxt   = prod;
          phase_nxt = PH_HL;
        end
        PH_HL: begin
          acc_nxt   = sum;
          phase_nxt = PH_LH;
        end
        default: begin
          // product complete: fold the high half down; start round two or finish
          x_nxt     = sum ^ (sum >> HASH_SHIFT);
          phase_nxt = PH_LL;
          round_nxt = 1'b1;
          if (round_r) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_LL;
      round_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign slot = x_r[SLOT_W-1:0];

endmodule

### hw/rtl/hashed_multimap_engine.sv
// Hashed multimap engine: node pool with rings, linear-probing key table, sequencer.
// Usage:
//   Requests enter on in_valid/in_ready, one at a time; in_ready is high only while
//   the sequencer is idle. Results leave on out_valid/out_ready through one output
//   register, so a new request is taken while the previous result still waits.
//   Every defined operation gives one result with out_last set, except visit, which
//   gives one result per value of the key and sets out_last on the final one; an
//   undefined operation code gives none. The slot hash is a start step, then a wait
//   on the shared 32x32 multiplier (three partial products per 64-bit multiply, two
//   multiplies). Each table probe is a registered slot memory read, then a compare.
//   Add may also pop the free list and link into the ring of a known key; count
//   walks the ring node by node, visit gives one result per ring node, and rejected
//   requests go straight to the output register.
//   A stalled receiver holds the output register; the sequencer waits before loading
//   the next result and does not lose any.
//   Reset: synchronous, active low; slot states and node alive bits clear at once,
//   with no clearing pass, and the block is ready on the first cycle after reset.
module hashed_multimap_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_operation,
  input  logic [hme_pkg::KEY_W-1:0]   in_key,
  input  logic [hme_pkg::VAL_W-1:0]   in_value,
  input  logic [hme_pkg::NODE_W-1:0]  in_node_index,
  input  logic [hme_pkg::NODE_W-1:0]  in_start_node,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [hme_pkg::NODE_W-1:0]  out_node,
  output logic [hme_pkg::KEY_W-1:0]   out_result_key,
  output logic [hme_pkg::VAL_W-1:0]   out_result_value,
  output logic                        out_node_alive,
  output logic [hme_pkg::CNT_W-1:0]   out_count,
  output logic                        out_last
);
  import hme_pkg::*;

  state_t             state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [NODE_W-1:0]  ni_r, ni_nxt, sn_r, sn_nxt, n_r, n_nxt;
  logic [NODE_W-1:0]  first_r, first_nxt, second_r, second_nxt, x_r, x_nxt;
  logic [SLOT_W-1:0]  probe_r, probe_nxt, pcnt_r, pcnt_nxt;
  logic [SLOT_W-1:0]  tomb_r, tomb_nxt, ins_r, ins_nxt, slot_r, slot_nxt;
  logic               tomb_v_r, tomb_v_nxt, ins_v_r, ins_v_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  res_t               res_r, res_nxt, out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [NODE_W:0]    ever_r, ever_nxt, free_r, free_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;

  // node pool
  logic [KEY_W-1:0]   ek_mem [NODES];
  logic [VAL_W-1:0]   ev_mem [NODES];
  logic [NODE_W-1:0]  rp_mem [NODES];
  logic [NODE_W:0]    rn_mem [NODES];
  logic               alive_r [NODES];
  logic [KEY_W-1:0]   ek_q;
  logic [VAL_W-1:0]   ev_q;
  logic [NODE_W-1:0]  rp_q;
  logic [NODE_W:0]    rn_q;
  logic [NODE_W-1:0]  nd_raddr, rp_wa, rn_wa, al_wa, rp_din;
  logic [NODE_W:0]    rn_din;
  logic               ent_we, rp_we, rn_we, al_we, al_din;

  // key table
  logic [KEY_W-1:0]   sk_mem [SLOTS];
  logic [NODE_W-1:0]  sf_mem [SLOTS];
  logic [1:0]         ss_r [SLOTS];
  logic [KEY_W-1:0]   sk_q;
  logic [NODE_W-1:0]  sf_q, sf_din;
  logic [1:0]         ss_q, ss_din;
  logic [SLOT_W-1:0]  sl_wa;
  logic               sk_we, sf_we, ss_we;

  logic               hash_start, hash_done;
  logic [SLOT_W-1:0]  hash_slot;

  logic               ni_lt, ni_ok, sn_ok, load_ok, hit, miss, tv, walk_end;
  logic [SLOT_W-1:0]  ts;
  logic [LIM_W-1:0]   lim_lhs;
  logic [CNT_W-1:0]   cnt_inc;
  logic [NODE_W-1:0]  nx;

  hme_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key_r),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  assign ni_lt   = {1'b0, in_node_index} < ever_r;
  assign ni_ok   = ni_lt && alive_r[in_node_index];
  assign sn_ok   = ({1'b0, in_start_node} < ever_r) && alive_r[in_start_node];
  assign lim_lhs = (LIM_W'(used_r) + LIM_W'(1)) * LIM_W'(LOAD_DEN);
  assign load_ok = lim_lhs < LIM_W'(SLOTS * LOAD_NUM);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign nx      = rn_q[NODE_W-1:0];
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    ni_nxt     = ni_r;
    sn_nxt     = sn_r;
    n_nxt      = n_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    x_nxt      = x_r;
    probe_nxt  = probe_r;
    pcnt_nxt   = pcnt_r;
    tomb_nxt   = tomb_r;
    tomb_v_nxt = tomb_v_r;
    ins_nxt    = ins_r;
    ins_v_nxt  = ins_v_r;
    slot_nxt   = slot_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    ever_nxt   = ever_r;
    free_nxt   = free_r;
    used_nxt   = used_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    nd_raddr   = n_r;
    ent_we     = 1'b0;
    rp_we      = 1'b0;
    rp_wa      = n_r;
    rp_din     = n_r;
    rn_we      = 1'b0;
    rn_wa      = n_r;
    rn_din     = free_r;
    al_we      = 1'b0;
    al_wa      = n_r;
    al_din     = 1'b0;
    sk_we      = 1'b0;
    sf_we      = 1'b0;
    ss_we      = 1'b0;
    sl_wa      = ins_r;
    sf_din     = n_r;
    ss_din     = SL_USED;
    hash_start = 1'b0;
    hit        = 1'b0;
    miss       = 1'b0;
    tv         = tomb_v_r;
    ts         = tomb_r;
    walk_end   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_operation;
          key_nxt = in_key;
          val_nxt = in_value;
          ni_nxt  = in_node_index;
          sn_nxt  = in_start_node;
          unique case (in_operation) inside
            OP_ADD: begin
              if (!free_r[NODE_W]) begin
                n_nxt     = free_r[NODE_W-1:0];
                state_nxt = S_POP_RD;
              end else if (!ever_r[NODE_W]) begin
                n_nxt     = ever_r[NODE_W-1:0];
                ever_nxt  = ever_r + (NODE_W+1)'(1);
                state_nxt = S_ADD_WR;
              end else begin
                res_nxt   = mk_res(ST_POOL_FULL, '0, '0, '0, 1'b0, '0, 1'b1);
                state_nxt = S_EMIT;
              end
            end
            OP_REMOVE: begin
              if (ni_ok) begin
                state_nxt = S_RM_RD;
              end else begin
                res_nxt   = mk_res(ST_INVALID, '0, '0, '0, 1'b0, '0, 1'b1);
                state_nxt = S_EMIT;
              end
            end
            OP_FIRST, OP_COUNT, OP_VISIT: state_nxt = S_HSTART;
            OP_NEXT: begin
              if (ni_ok && sn_ok) begin
                state_nxt = S_NX_RD;
              end else begin
                res_nxt   = mk_res(ST_INVALID, '0, '0, '0, 1'b0, '0, 1'b1);
                state_nxt = S_EMIT;
              end
            end
            OP_READ: begin
              if (ni_lt) begin
                state_nxt = S_RD_RD;
              end else begin
                res_nxt   = mk_res(ST_INVALID, '0, '0, '0, 1'b0, '0, 1'b1);
                state_nxt = S_EMIT;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP_RD: state_nxt = S_POP;
      S_POP: begin
        free_nxt  = rn_q;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        ent_we    = 1'b1;
        al_we     = 1'b1;
        al_din    = 1'b1;
        state_nxt = S_HSTART;
      end
      S_HSTART: begin
        hash_start = 1'b1;
        state_nxt  = S_HASH;
      end
      S_HASH: begin
        if (hash_done) begin
          probe_nxt  = hash_slot;
          pcnt_nxt   = '0;
          tomb_v_nxt = 1'b0;
          state_nxt  = S_PRB_RD;
        end
      end
      S_PRB_RD: state_nxt = S_PRB_CHK;
      S_PRB_CHK: begin
        if (ss_q == SL_EMPTY) begin
          miss      = 1'b1;
          ins_v_nxt = 1'b1;
          ins_nxt   = tv ? ts : probe_r;
        end else if (ss_q == SL_USED && sk_q == key_r) begin
          hit = 1'b1;
        end else begin
          // remember the first tombstone as the insert candidate
          if (ss_q == SL_TOMB && !tv) begin
            tv = 1'b1;
            ts = probe_r;
          end
          tomb_v_nxt = tv;
          tomb_nxt   = ts;
          if (pcnt_r == SLOT_W'(SLOTS - 1)) begin
            miss      = 1'b1;
            ins_v_nxt = tv;
            ins_nxt   = ts;
          end else begin
            probe_nxt = probe_r + SLOT_W'(1);
            pcnt_nxt  = pcnt_r + SLOT_W'(1);
            state_nxt = S_PRB_RD;
          end
        end
        if (hit) begin
          slot_nxt  = probe_r;
          first_nxt = sf_q;
          case (op_r)
            OP_ADD:    state_nxt = S_AF_RD;
            OP_REMOVE: state_nxt = S_RM_SLOT;
            OP_FIRST: begin
              res_nxt   = mk_res(ST_OK, sf_q, '0, '0, 1'b0, '0, 1'b1);
              state_nxt = S_EMIT;
            end
            default: begin
              n_nxt     = sf_q;
              cnt_nxt   = '0;
              state_nxt = S_WALK_RD;
            end
          endcase
        end else if (miss) begin
          case (op_r)
            OP_ADD:    state_nxt = S_ADD_NEW;
            OP_REMOVE: state_nxt = S_RM_FREE;
            default: begin
              res_nxt   = mk_res(ST_MISS, '0, '0, '0, 1'b0, '0, 1'b1);
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_ADD_NEW: begin
        if (load_ok && ins_v_r) begin
          rp_we    = 1'b1;
          rn_we    = 1'b1;
          rn_din   = {1'b0, n_r};
          sl_wa    = ins_r;
          ss_we    = 1'b1;
          sk_we    = 1'b1;
          sf_we    = 1'b1;
          used_nxt = used_r + USED_W'(1);
          res_nxt  = mk_res(ST_OK, n_r, '0, '0, 1'b0, '0, 1'b1);
        end else begin
          // give the node back to the free list
          al_we    = 1'b1;
          rn_we    = 1'b1;
          free_nxt = {1'b0, n_r};
          res_nxt  = mk_res(ST_LOAD, '0, '0, '0, 1'b0, '0, 1'b1);
        end
        state_nxt = S_EMIT;
      end
      S_AF_RD: begin
        nd_raddr  = first_r;
        state_nxt = S_AF_LINK;
      end
      S_AF_LINK: begin
        second_nxt = nx;
        rp_we      = 1'b1;
        rp_din     = first_r;
        rn_we      = 1'b1;
        rn_din     = {1'b0, nx};
        state_nxt  = S_AF_LINK2;
      end
      S_AF_LINK2: begin
        rn_we     = 1'b1;
        rn_wa     = first_r;
        rn_din    = {1'b0, n_r};
        rp_we     = 1'b1;
        rp_wa     = second_r;
        rp_din    = n_r;
        res_nxt   = mk_res(ST_OK, n_r, '0, '0, 1'b0, '0, 1'b1);
        state_nxt = S_EMIT;
      end
      S_RM_RD: begin
        nd_raddr  = ni_r;
        state_nxt = S_RM_LINK;
      end
      S_RM_LINK: begin
        // unlink: next of prev gets next, prev of next gets prev
        rn_we     = 1'b1;
        rn_wa     = rp_q;
        rn_din    = {1'b0, nx};
        rp_we     = 1'b1;
        rp_wa     = nx;
        rp_din    = rp_q;
        x_nxt     = nx;
        key_nxt   = ek_q;
        state_nxt = S_HSTART;
      end
      S_RM_SLOT: begin
        sl_wa = slot_r;
        if (first_r == ni_r) begin
          if (x_r == ni_r) begin
            ss_we    = 1'b1;
            ss_din   = SL_TOMB;
            used_nxt = used_r - USED_W'(1);
          end else begin
            sf_we  = 1'b1;
            sf_din = x_r;
          end
        end
        state_nxt = S_RM_FREE;
      end
      S_RM_FREE: begin
        al_we     = 1'b1;
        al_wa     = ni_r;
        rn_we     = 1'b1;
        rn_wa     = ni_r;
        free_nxt  = {1'b0, ni_r};
        res_nxt   = mk_res(ST_OK, '0, '0, '0, 1'b0, '0, 1'b1);
        state_nxt = S_EMIT;
      end
      S_NX_RD: begin
        nd_raddr  = ni_r;
        state_nxt = S_NX;
      end
      S_NX: begin
        if (nx == sn_r) res_nxt = mk_res(ST_MISS, '0, '0, '0, 1'b0, '0, 1'b1);
        else            res_nxt = mk_res(ST_OK, nx, '0, '0, 1'b0, '0, 1'b1);
        state_nxt = S_EMIT;
      end
      S_RD_RD: begin
        nd_raddr  = ni_r;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (alive_r[ni_r]) res_nxt = mk_res(ST_OK, '0, ek_q, ev_q, 1'b1, '0, 1'b1);
        else               res_nxt = mk_res(ST_INVALID, '0, ek_q, ev_q, 1'b0, '0, 1'b1);
        state_nxt = S_EMIT;
      end
      S_WALK_RD: state_nxt = S_WALK;
      S_WALK: begin
        cnt_nxt  = cnt_inc;
        n_nxt    = nx;
        walk_end = (nx == first_r) || (cnt_inc == CNT_W'(NODES));
        if (op_r == OP_COUNT) begin
          if (walk_end) begin
            res_nxt   = mk_res(ST_OK, '0, '0, '0, 1'b0, cnt_inc, 1'b1);
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_WALK_RD;
          end
        end else begin
          res_nxt   = mk_res(ST_OK, n_r, '0, ev_q, 1'b0, '0, walk_end);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = res_r.last ? S_IDLE : S_WALK_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ever_r      <= '0;
      free_r      <= NODE_END;
      used_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ever_r      <= ever_nxt;
      free_r      <= free_nxt;
      used_r      <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    ni_r     <= ni_nxt;
    sn_r     <= sn_nxt;
    n_r      <= n_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
    x_r      <= x_nxt;
    probe_r  <= probe_nxt;
    pcnt_r   <= pcnt_nxt;
    tomb_r   <= tomb_nxt;
    tomb_v_r <= tomb_v_nxt;
    ins_r    <= ins_nxt;
    ins_v_r  <= ins_v_nxt;
    slot_r   <= slot_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ek_mem[n_r] <= key_r;
      ev_mem[n_r] <= val_r;
    end
    ek_q <= ek_mem[nd_raddr];
    ev_q <= ev_mem[nd_raddr];
  end

  always_ff @(posedge clk) begin
    if (rp_we) rp_mem[rp_wa] <= rp_din;
    rp_q <= rp_mem[nd_raddr];
  end

  always_ff @(posedge clk) begin
    if (rn_we) rn_mem[rn_wa] <= rn_din;
    rn_q <= rn_mem[nd_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) alive_r[i] <= 1'b0;
    end else if (al_we) begin
      alive_r[al_wa] <= al_din;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_we) sk_mem[sl_wa] <= key_r;
    sk_q <= sk_mem[probe_r];
  end

  always_ff @(posedge clk) begin
    if (sf_we) sf_mem[sl_wa] <= sf_din;
    sf_q <= sf_mem[probe_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) ss_r[i] <= SL_EMPTY;
    end else if (ss_we) begin
      ss_r[sl_wa] <= ss_din;
    end
  end

  always_ff @(posedge clk) begin
    ss_q <= ss_r[probe_r];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_node         = out_r.node;
  assign out_result_key   = out_r.key;
  assign out_result_value = out_r.value;
  assign out_node_alive   = out_r.alive;
  assign out_count        = out_r.count;
  assign out_last         = out_r.last;

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= NODE_END)
    else $error("free list head beyond pool");

  a_ever_range: assert property (@(posedge clk) disable iff (!rst_n)
    ever_r <= NODE_END)
    else $error("fresh node count beyond pool");

  a_load_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (LIM_W'(used_r) * LIM_W'(LOAD_DEN)) < LIM_W'(SLOTS * LOAD_NUM))
    else $error("used slot count passed the load limit");

  a_hash_wait: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> state_r == S_HASH)
    else $error("hash finished outside the hash wait");

  a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_ready) |=> state_r == S_EMIT)
    else $error("result left while output register was full");

endmodule

### tb/hashed_multimap_engine_tb.sv
// Self-checking testbench for the hashed multimap engine: directed table, then random phases.
`timescale 1ns / 1ps

module hashed_multimap_engine_tb;
  import hme_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 300;
  localparam logic [2:0] OP_UNDEF = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_operation = OP_ADD;
  logic [KEY_W-1:0]  in_key = '0;
  logic [VAL_W-1:0]  in_value = '0;
  logic [NODE_W-1:0] in_node_index = '0;
  logic [NODE_W-1:0] in_start_node = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_status;
  logic [NODE_W-1:0] out_node;
  logic [KEY_W-1:0]  out_result_key;
  logic [VAL_W-1:0]  out_result_value;
  logic              out_node_alive;
  logic [CNT_W-1:0]  out_count;
  logic              out_last;

  hashed_multimap_engine dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the engine state
  logic [KEY_W-1:0] pool_key [NODES];
  logic [VAL_W-1:0] pool_val [NODES];
  int               ring_prv [NODES];
  int               ring_nxt [NODES];
  bit               pool_live [NODES];
  int               ever_used;
  int               free_top;
  logic [1:0]       slot_state [SLOTS];
  logic [KEY_W-1:0] slot_key [SLOTS];
  int               slot_head [SLOTS];
  int               used_slots;

  res_t pending_results [$];
  res_t fresh [$];
  int   error_count = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   quiet_cycles = 0;

  function automatic int home_of(logic [KEY_W-1:0] k);
    k = k ^ (k >> HASH_SHIFT);
    k = k * 64'hff51afd7ed558ccd;
    k = k ^ (k >> HASH_SHIFT);
    k = k * 64'hc4ceb9fe1a85ec53;
    k = k ^ (k >> HASH_SHIFT);
    return int'(k % SLOTS);
  endfunction

  function automatic int find_slot(logic [KEY_W-1:0] k);
    int i;
    i = home_of(k);
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_state[i] == SL_EMPTY) return SLOTS;
      if (slot_state[i] == SL_USED && slot_key[i] == k) return i;
      i = (i + 1) % SLOTS;
    end
    return SLOTS;
  endfunction

  function automatic int claim_slot(logic [KEY_W-1:0] k);
    int i;
    int tomb;
    i = home_of(k);
    tomb = SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_state[i] == SL_EMPTY) return (tomb != SLOTS) ? tomb : i;
      if (slot_state[i] == SL_TOMB) begin
        if (tomb == SLOTS) tomb = i;
      end else if (slot_key[i] == k) begin
        return i;
      end
      i = (i + 1) % SLOTS;
    end
    return tomb;
  endfunction

  function automatic bit live_node(int n);
    return n < ever_used && pool_live[n];
  endfunction

  function automatic res_t mk(logic [2:0] st, int nd = 0, logic [KEY_W-1:0] k = '0,
                              logic [VAL_W-1:0] v = '0, bit al = 0, int c = 0, bit lst = 1);
    res_t r;
    r.status = st;
    r.node   = NODE_W'(nd);
    r.key    = k;
    r.value  = v;
    r.alive  = al;
    r.count  = CNT_W'(c);
    r.last   = lst;
    return r;
  endfunction

  // Apply one request to the mirror and append its results to fresh
  task automatic predict_request(logic [2:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                 int ni, int sn);
    int n, s, s2, hd, sec, p, x, cnt, nx;
    bit done;
    case (op)
      OP_ADD: begin
        if (free_top < NODES) begin
          n = free_top;
          free_top = ring_nxt[n];
        end else if (ever_used < NODES) begin
          n = ever_used;
          ever_used = ever_used + 1;
        end else begin
          fresh.push_back(mk(ST_POOL_FULL));
          return;
        end
        pool_key[n] = k;
        pool_val[n] = v;
        pool_live[n] = 1;
        s = find_slot(k);
        if (s == SLOTS) begin
          s2 = SLOTS;
          if ((used_slots + 1) * LOAD_DEN < SLOTS * LOAD_NUM) s2 = claim_slot(k);
          if (s2 == SLOTS) begin
            pool_live[n] = 0;
            ring_nxt[n] = free_top;
            free_top = n;
            fresh.push_back(mk(ST_LOAD));
            return;
          end
          ring_prv[n] = n;
          ring_nxt[n] = n;
          if (slot_state[s2] != SL_USED) used_slots++;
          slot_state[s2] = SL_USED;
          slot_key[s2] = k;
          slot_head[s2] = n;
        end else begin
          hd = slot_head[s];
          sec = ring_nxt[hd];
          ring_prv[n] = hd;
          ring_nxt[n] = sec;
          ring_nxt[hd] = n;
          ring_prv[sec] = n;
        end
        fresh.push_back(mk(ST_OK, n));
      end
      OP_REMOVE: begin
        if (!live_node(ni)) begin
          fresh.push_back(mk(ST_INVALID));
          return;
        end
        p = ring_prv[ni];
        x = ring_nxt[ni];
        ring_nxt[p] = x;
        ring_prv[x] = p;
        s = find_slot(pool_key[ni]);
        if (s != SLOTS && slot_head[s] == ni) begin
          if (x == ni) begin
            slot_state[s] = SL_TOMB;
            used_slots--;
          end else begin
            slot_head[s] = x;
          end
        end
        pool_live[ni] = 0;
        ring_nxt[ni] = free_top;
        free_top = ni;
        fresh.push_back(mk(ST_OK));
      end
      OP_FIRST: begin
        s = find_slot(k);
        fresh.push_back(s == SLOTS ? mk(ST_MISS) : mk(ST_OK, slot_head[s]));
      end
      OP_NEXT: begin
        if (!live_node(ni) || !live_node(sn)) begin
          fresh.push_back(mk(ST_INVALID));
        end else begin
          n = ring_nxt[ni];
          fresh.push_back(n == sn ? mk(ST_MISS) : mk(ST_OK, n));
        end
      end
      OP_READ: begin
        if (ni >= ever_used) fresh.push_back(mk(ST_INVALID));
        else if (pool_live[ni]) fresh.push_back(mk(ST_OK, 0, pool_key[ni], pool_val[ni], 1));
        else fresh.push_back(mk(ST_INVALID, 0, pool_key[ni], pool_val[ni], 0));
      end
      OP_COUNT: begin
        s = find_slot(k);
        if (s == SLOTS) begin
          fresh.push_back(mk(ST_MISS));
        end else begin
          hd = slot_head[s];
          n = hd;
          cnt = 0;
          do begin
            cnt++;
            n = ring_nxt[n];
          end while (n != hd && cnt < NODES);
          fresh.push_back(mk(ST_OK, 0, '0, '0, 0, cnt));
        end
      end
      OP_VISIT: begin
        s = find_slot(k);
        if (s == SLOTS) begin
          fresh.push_back(mk(ST_MISS));
        end else begin
          hd = slot_head[s];
          n = hd;
          cnt = 0;
          done = 0;
          while (!done) begin
            nx = ring_nxt[n];
            done = (nx == hd) || (cnt + 1 >= NODES);
            fresh.push_back(mk(ST_OK, n, '0, pool_val[n], 0, 0, done));
            cnt++;
            n = nx;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Present one request, hold it until taken, then record what it should produce
  task automatic send_request(logic [2:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                              logic [NODE_W-1:0] ni, logic [NODE_W-1:0] sn,
                              bit typed = 0, res_t want = '0);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_operation  <= op;
    in_key        <= k;
    in_value      <= v;
    in_node_index <= ni;
    in_start_node <= sn;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    fresh.delete();
    predict_request(op, k, v, int'(ni), int'(sn));
    if (typed) pending_results.push_back(want);
    else foreach (fresh[i]) pending_results.push_back(fresh[i]);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d node %0d", out_status, out_node);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_node !== want.node) begin
          $error("node: expected %0d, got %0d", want.node, out_node);
          error_count++;
        end
        if (out_result_key !== want.key) begin
          $error("result_key: expected %h, got %h", want.key, out_result_key);
          error_count++;
        end
        if (out_result_value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, out_result_value);
          error_count++;
        end
        if (out_node_alive !== want.alive) begin
          $error("node_alive: expected %0d, got %0d", want.alive, out_node_alive);
          error_count++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  typedef struct {
    logic [2:0]        op;
    logic [KEY_W-1:0]  k;
    logic [VAL_W-1:0]  v;
    logic [NODE_W-1:0] ni;
    logic [NODE_W-1:0] sn;
    bit                typed;
    res_t              want;
  } stim_row_t;

  localparam logic [KEY_W-1:0] KEY_A   = 64'h0123_4567_89ab_cdef;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_MIN = '0;

  initial begin
    stim_row_t        directed [$];
    logic [KEY_W-1:0] key_pool [8];
    int               add_pct [4];
    int               idle_pct [4];
    int               stall_pct [4];
    int               roll;
    logic [2:0]       op;
    logic [KEY_W-1:0] k;
    logic [NODE_W-1:0] ni;
    logic [NODE_W-1:0] sn;
    int               sent;

    foreach (pool_live[i]) pool_live[i] = 0;
    foreach (slot_state[i]) slot_state[i] = SL_EMPTY;
    ever_used = 0;
    free_top = NODES;
    used_slots = 0;

    directed = '{
      '{OP_READ,   KEY_MIN, 0, 0, 0, 1, mk(ST_INVALID)},
      '{OP_FIRST,  KEY_A,   0, 0, 0, 1, mk(ST_MISS)},
      '{OP_COUNT,  KEY_A,   0, 0, 0, 1, mk(ST_MISS)},
      '{OP_VISIT,  KEY_A,   0, 0, 0, 1, mk(ST_MISS)},
      '{OP_REMOVE, KEY_MIN, 0, 0, 0, 1, mk(ST_INVALID)},
      '{OP_NEXT,   KEY_MIN, 0, 0, 0, 1, mk(ST_INVALID)},
      '{OP_ADD,    KEY_A,   32'h0, 0, 0, 1, mk(ST_OK, 0)},
      '{OP_ADD,    KEY_A,   32'hffff_ffff, 63, 63, 1, mk(ST_OK, 1)},
      '{OP_ADD,    KEY_MAX, 32'h5a5a_a5a5, 0, 0, 1, mk(ST_OK, 2)},
      '{OP_ADD,    KEY_MIN, 32'h1, 0, 0, 1, mk(ST_OK, 3)},
      '{OP_VISIT,  KEY_A,   0, 0, 0, 0, '0},
      '{OP_COUNT,  KEY_A,   0, 0, 0, 0, '0},
      '{OP_FIRST,  KEY_A,   0, 0, 0, 0, '0},
      '{OP_NEXT,   KEY_A,   0, 0, 0, 0, '0},
      '{OP_NEXT,   KEY_A,   0, 1, 0, 0, '0},
      '{OP_READ,   KEY_MIN, 0, 63, 0, 1, mk(ST_INVALID)},
      '{OP_READ,   KEY_MIN, 0, 2, 0, 0, '0},
      '{OP_REMOVE, KEY_MIN, 0, 0, 0, 1, mk(ST_OK)},
      '{OP_READ,   KEY_MIN, 0, 0, 0, 0, '0},
      '{OP_REMOVE, KEY_MIN, 0, 0, 0, 1, mk(ST_INVALID)},
      '{OP_FIRST,  KEY_A,   0, 0, 0, 0, '0},
      '{OP_UNDEF,  KEY_MAX, 32'hffff_ffff, 63, 63, 0, '0},
      '{OP_ADD,    KEY_MAX, 32'h7, 0, 0, 0, '0},
      '{OP_VISIT,  KEY_MAX, 0, 0, 0, 0, '0},
      '{OP_REMOVE, KEY_MIN, 0, 3, 0, 1, mk(ST_OK)},
      '{OP_COUNT,  KEY_MIN, 0, 0, 0, 1, mk(ST_MISS)}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_request(directed[i].op, directed[i].k, directed[i].v, directed[i].ni,
                   directed[i].sn, directed[i].typed, directed[i].want);

    key_pool[0] = KEY_A;
    key_pool[1] = KEY_MAX;
    key_pool[2] = KEY_MIN;
    for (int i = 3; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    // Phase mix: no idling, sender idle, receiver stalls, both; the second one fills the pool
    add_pct   = '{40, 75, 25, 35};
    idle_pct  = '{0, 53, 0, 8};
    stall_pct = '{0, 0, 53, 8};

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_pct[ph];
      receiver_stall_pct = stall_pct[ph];
      sent = 0;
      while (sent < 84) begin
        roll = $urandom_range(99);
        if (roll < add_pct[ph]) op = OP_ADD;
        else if (roll < add_pct[ph] + 15) op = OP_REMOVE;
        else if (roll >= 97) op = OP_UNDEF;
        else op = 3'($urandom_range(2, 6));
        k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : {$urandom, $urandom};
        if (ever_used > 0 && $urandom_range(9) < 8) begin
          ni = NODE_W'($urandom_range(ever_used - 1));
          sn = ($urandom_range(3) == 0) ? ni : NODE_W'($urandom_range(ever_used - 1));
        end else begin
          ni = NODE_W'($urandom);
          sn = NODE_W'($urandom);
        end
        send_request(op, k, $urandom, ni, sn);
        if (op != OP_UNDEF) sent++;
      end
      // Hold off until the engine has drained everything
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
    end

    receiver_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
